// ===== sv/dde_pkg.sv =====
package dde_pkg;

  localparam int DIGIT_POSITIONS = 64;
  localparam int IDX_W           = $clog2(DIGIT_POSITIONS);
  localparam int NUM_W           = 32;
  localparam int CNT_W           = $clog2(NUM_W);
  localparam int DIGIT_W         = 4;
  localparam int LEFT_W          = 4;

  typedef logic [2:0]         req_type_t;
  typedef logic [7:0]         start_t;
  typedef logic [NUM_W-1:0]   number_t;
  typedef logic [IDX_W-1:0]   digit_idx_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [7:0]         seg_cnt_t;

  localparam req_type_t REQ_DEC8  = 3'd0;
  localparam req_type_t REQ_DEC16 = 3'd1;
  localparam req_type_t REQ_DEC32 = 3'd2;
  localparam req_type_t REQ_HEX8  = 3'd3;
  localparam req_type_t REQ_HEX16 = 3'd4;
  localparam req_type_t REQ_HEX32 = 3'd5;

  localparam seg_cnt_t SEG_CNT_RESET = 8'd8;

endpackage

// ===== sv/dde_in_if.sv =====
interface dde_in_if;
  import dde_pkg::*;

  logic      valid;
  logic      ready;
  req_type_t req_type;
  start_t    start_index;
  number_t   number;

  modport source (output valid, output req_type, output start_index, output number,
                  input ready);
  modport sink (input valid, input req_type, input start_index, input number,
                output ready);
endinterface

// ===== sv/dde_out_if.sv =====
interface dde_out_if;
  import dde_pkg::*;

  logic       valid;
  logic       ready;
  digit_idx_t digit_index;
  digit_t     digit_value;
  logic       last_digit;

  modport source (output valid, output digit_index, output digit_value, output last_digit,
                  input ready);
  modport sink (input valid, input digit_index, input digit_value, input last_digit,
                output ready);
endinterface

// ===== sv/display_digit_expander.sv =====
// Channel | Dir | Payload                               | Handshake
// in_ch   | in  | req_type, start_index, number         | valid/ready
// out_ch  | out | digit_index, digit_value, last_digit  | valid/ready
// cfg     | in  | cfg_wdata (segment count)             | cfg_we, no wait
//
// Decimal: one restoring divide-by-10 step per cycle over 8, 16 or 32 bits, then the
// digit is handed over in S_EMIT, which waits while the output register is full.
// Hex: one nibble per cycle while the output register is free.
// Synchronous active-low reset; segment count resets to 8.
// A full output register stalls the sequencer; input is taken only when idle.
module display_digit_expander (
  input  logic           clk,
  input  logic           rst_n,
  dde_in_if.sink         in_ch,
  dde_out_if.source      out_ch,
  input  logic           cfg_we,
  input  dde_pkg::seg_cnt_t cfg_wdata
);
  import dde_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_EMIT} state_t;

  state_t              state_r, state_nxt;
  seg_cnt_t            seg_cnt_r;
  number_t             num_r, num_nxt;
  digit_t              rem_r, rem_nxt;
  logic [CNT_W-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [LEFT_W-1:0]   left_r, left_nxt;
  digit_idx_t          pos_r, pos_nxt;
  logic                hex_r, hex_nxt;
  logic [1:0]          wsel_r, wsel_nxt;

  logic                out_valid_r, out_valid_nxt;
  digit_idx_t          out_idx_r, out_idx_nxt;
  digit_t              out_val_r, out_val_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_fire, out_free;
  logic [4:0]          trial;
  logic                q_bit;
  logic [LEFT_W-1:0]   dec_w, dec_cnt;
  logic [CNT_W-1:0]    bits_m1;
  number_t             aligned;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.digit_index = out_idx_r;
  assign out_ch.digit_value = out_val_r;
  assign out_ch.last_digit  = out_last_r;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign q_bit = (trial >= 5'd10);

  // quotient sits in the low bits after a pass; move it back to the top
  always_comb begin
    case (wsel_r)
      2'd0:    aligned = num_r << (NUM_W - 8);
      2'd1:    aligned = num_r << (NUM_W - 16);
      default: aligned = num_r;
    endcase
  end

  always_comb begin
    case (wsel_r)
      2'd0:    bits_m1 = CNT_W'(7);
      2'd1:    bits_m1 = CNT_W'(15);
      default: bits_m1 = CNT_W'(NUM_W - 1);
    endcase
  end

  always_comb begin
    case (in_ch.req_type)
      REQ_DEC8:  dec_w = LEFT_W'(3);
      REQ_DEC16: dec_w = LEFT_W'(5);
      default:   dec_w = LEFT_W'(10);
    endcase
    dec_cnt = (seg_cnt_r < {4'd0, dec_w}) ? seg_cnt_r[LEFT_W-1:0] : dec_w;
  end

  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    bit_cnt_nxt   = bit_cnt_r;
    left_nxt      = left_r;
    pos_nxt       = pos_r;
    hex_nxt       = hex_r;
    wsel_nxt      = wsel_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          pos_nxt = in_ch.start_index[IDX_W-1:0];
          rem_nxt = '0;
          case (in_ch.req_type)
            REQ_DEC8: begin
              hex_nxt     = 1'b0;
              wsel_nxt    = 2'd0;
              num_nxt     = {in_ch.number[7:0], 24'd0};
              bit_cnt_nxt = CNT_W'(7);
              left_nxt    = dec_cnt;
              state_nxt   = (dec_cnt == '0) ? S_IDLE : S_DIV;
            end
            REQ_DEC16: begin
              hex_nxt     = 1'b0;
              wsel_nxt    = 2'd1;
              num_nxt     = {in_ch.number[15:0], 16'd0};
              bit_cnt_nxt = CNT_W'(15);
              left_nxt    = dec_cnt;
              state_nxt   = (dec_cnt == '0) ? S_IDLE : S_DIV;
            end
            REQ_DEC32: begin
              hex_nxt     = 1'b0;
              wsel_nxt    = 2'd2;
              num_nxt     = in_ch.number;
              bit_cnt_nxt = CNT_W'(NUM_W - 1);
              left_nxt    = dec_cnt;
              state_nxt   = (dec_cnt == '0) ? S_IDLE : S_DIV;
            end
            REQ_HEX8: begin
              hex_nxt   = 1'b1;
              num_nxt   = in_ch.number;
              left_nxt  = LEFT_W'(2);
              state_nxt = S_EMIT;
            end
            REQ_HEX16: begin
              hex_nxt   = 1'b1;
              num_nxt   = in_ch.number;
              left_nxt  = LEFT_W'(4);
              state_nxt = S_EMIT;
            end
            REQ_HEX32: begin
              hex_nxt   = 1'b1;
              num_nxt   = in_ch.number;
              left_nxt  = LEFT_W'(8);
              state_nxt = S_EMIT;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        rem_nxt     = q_bit ? DIGIT_W'(trial - 5'd10) : trial[DIGIT_W-1:0];
        num_nxt     = {num_r[NUM_W-2:0], q_bit};
        bit_cnt_nxt = bit_cnt_r - 1'b1;
        if (bit_cnt_r == '0) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = pos_r;
          out_val_nxt   = hex_r ? num_r[DIGIT_W-1:0] : rem_r;
          out_last_nxt  = (left_r == LEFT_W'(1));
          pos_nxt       = pos_r + 1'b1;
          left_nxt      = left_r - 1'b1;
          if (left_r == LEFT_W'(1)) begin
            state_nxt = S_IDLE;
          end else if (hex_r) begin
            num_nxt = num_r >> DIGIT_W;
          end else begin
            num_nxt     = aligned;
            rem_nxt     = '0;
            bit_cnt_nxt = bits_m1;
            state_nxt   = S_DIV;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      seg_cnt_r   <= SEG_CNT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        seg_cnt_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    left_r     <= left_nxt;
    pos_r      <= pos_nxt;
    hex_r      <= hex_nxt;
    wsel_r     <= wsel_nxt;
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  a_dec_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !hex_r) |-> (rem_r < DIGIT_W'(10)))
    else $error("decimal remainder out of range");

  a_div_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_EMIT) |-> (left_r != '0))
    else $error("sequencer busy with no digits left");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result raised outside emit");

endmodule
